@@ rtl/c2p_pkg.sv @@
// c2p_pkg: shared widths, angle constants and the CORDIC arctangent table
// for the Cartesian to polar converter. No dependencies.
`timescale 1ns / 1ps
package c2p_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 28;   // CORDIC datapath / angle accumulator width
  localparam int FRAC_SHIFT   = 8;
  localparam int RHO_N        = 24;   // root bits of round(sqrt(x^2+y^2) * 2^8)
  localparam int RAD_N        = 16;   // root bits of the output radius
  localparam int SQ_W         = 32;   // width of squared sums

  localparam logic signed [CW-1:0] HALF_PI_24  = 28'sd26353589;
  localparam logic signed [CW-1:0] HALF_PI_Q13 = 28'sd12868;
  localparam logic signed [CW-1:0] PI_Q13      = 28'sd25736;
  localparam logic signed [CW-1:0] ROUND_Q13   = 28'sd1024;

  typedef struct packed {
    logic                  mode;
    logic                  xzero;
    logic                  yzero;
    logic                  yneg;
    logic [DATA_WIDTH-1:0] z;
  } side_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [CW-1:0] atan_entry(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:       v = 28'sd13176795;
      1:       v = 28'sd7778716;
      2:       v = 28'sd4110060;
      3:       v = 28'sd2086331;
      4:       v = 28'sd1047214;
      5:       v = 28'sd524117;
      6:       v = 28'sd262123;
      7:       v = 28'sd131069;
      8:       v = 28'sd65536;
      9:       v = 28'sd32768;
      10:      v = 28'sd16384;
      11:      v = 28'sd8192;
      12:      v = 28'sd4096;
      13:      v = 28'sd2048;
      14:      v = 28'sd1024;
      15:      v = 28'sd512;
      16:      v = 28'sd256;
      17:      v = 28'sd128;
      18:      v = 28'sd64;
      19:      v = 28'sd32;
      20:      v = 28'sd16;
      21:      v = 28'sd8;
      22:      v = 28'sd4;
      23:      v = 28'sd2;
      24:      v = 28'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/c2p_if.sv @@
// c2p_in_if / c2p_out_if: valid/ready channels of the converter.
// Depends on c2p_pkg for the data width.
`timescale 1ns / 1ps
interface c2p_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [c2p_pkg::DATA_WIDTH-1:0] coord_x;
  logic signed [c2p_pkg::DATA_WIDTH-1:0] coord_y;
  logic signed [c2p_pkg::DATA_WIDTH-1:0] coord_z;
  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

interface c2p_out_if;
  logic                                  valid;
  logic                                  ready;
  logic        [c2p_pkg::DATA_WIDTH-1:0] radius;
  logic signed [14:0]                    azimuth;
  logic signed [c2p_pkg::DATA_WIDTH-1:0] third_coord;
  logic                                  invalid;
  modport source (output valid, radius, azimuth, third_coord, invalid, input ready);
  modport sink   (input valid, radius, azimuth, third_coord, invalid, output ready);
endinterface

@@ rtl/c2p_delay.sv @@
// c2p_delay: enable-gated shift line that aligns side data with the pipeline.
// No dependencies.
`timescale 1ns / 1ps
module c2p_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] tap_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q_o = tap_r[DEPTH-1];
endmodule

@@ rtl/c2p_sqrt.sv @@
// c2p_sqrt: pipelined digit-by-digit square root, one root bit per stage,
// followed by a round-to-nearest stage. Depends on nothing.
`timescale 1ns / 1ps
module c2p_sqrt #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] s_i,
  output logic [N-1:0]   root_o
);
  localparam int RW = 2 * N + 2;

  logic [RW-1:0] rem_r  [0:N];
  logic [N-1:0]  root_r [0:N];
  logic [N-1:0]  round_r;

  assign rem_r[0]  = RW'(s_i);
  assign root_r[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [RW-1:0] trial;
    assign trial = (RW'(root_r[k]) << (B + 1)) | (RW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[k] >= trial) begin
          rem_r[k+1]  <= rem_r[k] - trial;
          root_r[k+1] <= root_r[k] | (N'(1) << B);
        end else begin
          rem_r[k+1]  <= rem_r[k];
          root_r[k+1] <= root_r[k];
        end
      end
    end
  end

  // round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      round_r <= root_r[N] + N'(rem_r[N] > RW'(root_r[N]));
    end
  end

  assign root_o = round_r;
endmodule

@@ rtl/c2p_cordic.sv @@
// c2p_cordic: vectoring CORDIC, one micro-rotation per register stage.
// Depends on c2p_pkg for the datapath width and the arctangent table.
`timescale 1ns / 1ps
module c2p_cordic #(
  parameter int STEPS = c2p_pkg::CORDIC_STEPS
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [c2p_pkg::CW-1:0]  vx_i,
  input  logic signed [c2p_pkg::CW-1:0]  vy_i,
  input  logic signed [c2p_pkg::CW-1:0]  acc_i,
  output logic signed [c2p_pkg::CW-1:0]  acc_o
);
  logic signed [c2p_pkg::CW-1:0] vx_r  [0:STEPS];
  logic signed [c2p_pkg::CW-1:0] vy_r  [0:STEPS];
  logic signed [c2p_pkg::CW-1:0] acc_r [0:STEPS];

  assign vx_r[0]  = vx_i;
  assign vy_r[0]  = vy_i;
  assign acc_r[0] = acc_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [c2p_pkg::CW-1:0] dx, dy;
    assign dx = vy_r[i] >>> i;
    assign dy = vx_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_r[i][c2p_pkg::CW-1]) begin
          vx_r[i+1]  <= vx_r[i] + dx;
          vy_r[i+1]  <= vy_r[i] - dy;
          acc_r[i+1] <= acc_r[i] + c2p_pkg::atan_entry(i);
        end else begin
          vx_r[i+1]  <= vx_r[i] - dx;
          vy_r[i+1]  <= vy_r[i] + dy;
          acc_r[i+1] <= acc_r[i] - c2p_pkg::atan_entry(i);
        end
      end
    end
  end

  assign acc_o = acc_r[STEPS];
endmodule

@@ rtl/cartesian_to_polar_coords.sv @@
// Channel   Dir  Payload
// in_ch     in   action, coord_x, coord_y, coord_z
// out_ch    out  radius, azimuth, third_coord, invalid
//
// One point enters every cycle while out_ch is not stalled.
// The depth is set by the 24-stage square root for the planar radius
// followed by the polar-angle CORDIC, one micro-rotation per stage.
// Reset clears the valid bits only; the datapath carries no state.
// A stall on out_ch freezes the whole pipeline and deasserts in_ch.ready.
// Depends on c2p_pkg, c2p_if, c2p_delay, c2p_sqrt, c2p_cordic.
`timescale 1ns / 1ps
module cartesian_to_polar_coords #(
  parameter int CORDIC_STEPS = c2p_pkg::CORDIC_STEPS
) (
  input logic        clk,
  input logic        rst_n,
  c2p_in_if.sink     in_ch,
  c2p_out_if.source  out_ch
);
  localparam int DW  = c2p_pkg::DATA_WIDTH;
  localparam int CW  = c2p_pkg::CW;
  localparam int LAT = 30 + CORDIC_STEPS;
  localparam int SW  = $bits(c2p_pkg::side_t);

  logic           en;
  logic [LAT-1:0] valid_r;

  assign en          = out_ch.ready | ~out_ch.valid;
  assign in_ch.ready = en;
  assign out_ch.valid = valid_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAT-2:0], in_ch.valid};
    end
  end

  // stage a: capture the transaction
  logic                 a_mode_r;
  logic signed [DW-1:0] a_x_r, a_y_r, a_z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode_r <= in_ch.action;
      a_x_r    <= in_ch.coord_x;
      a_y_r    <= in_ch.coord_y;
      a_z_r    <= in_ch.coord_z;
    end
  end

  // stage b: squares and azimuth CORDIC start vector
  logic signed [2*DW-1:0] xx, yy, zz;
  logic signed [CW-1:0]   xe, ye;
  logic [c2p_pkg::SQ_W-1:0] b_xx_r, b_yy_r, b_zz_r;
  logic signed [CW-1:0]   b_ax_r, b_ay_r;
  c2p_pkg::side_t         b_side_r;

  assign xx = a_x_r * a_x_r;
  assign yy = a_y_r * a_y_r;
  assign zz = a_z_r * a_z_r;
  assign xe = CW'(a_x_r);
  assign ye = CW'(a_y_r);

  always_ff @(posedge clk) begin
    if (en) begin
      b_xx_r <= c2p_pkg::SQ_W'(xx);
      b_yy_r <= c2p_pkg::SQ_W'(yy);
      b_zz_r <= c2p_pkg::SQ_W'(zz);
      // fold the left half-plane onto the right one
      b_ax_r <= (a_x_r[DW-1] ? -xe : xe) <<< c2p_pkg::FRAC_SHIFT;
      b_ay_r <= (a_x_r[DW-1] ? -ye : ye) <<< c2p_pkg::FRAC_SHIFT;
      b_side_r.mode  <= a_mode_r;
      b_side_r.xzero <= (a_x_r == '0);
      b_side_r.yzero <= (a_y_r == '0);
      b_side_r.yneg  <= a_y_r[DW-1];
      b_side_r.z     <= a_z_r;
    end
  end

  // stage c: sums of squares
  logic [c2p_pkg::SQ_W-1:0] c_sxy_r, c_srad_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_sxy_r  <= b_xx_r + b_yy_r;
      c_srad_r <= b_side_r.mode ? (b_xx_r + b_yy_r + b_zz_r) : (b_xx_r + b_yy_r);
    end
  end

  logic [c2p_pkg::RHO_N-1:0] rho;
  logic [c2p_pkg::RAD_N-1:0] rad_early, rad_final;

  // planar sum scaled by 2^16 gives the root scaled by 2^8
  c2p_sqrt #(.N(c2p_pkg::RHO_N)) u_rho_sqrt (
    .clk(clk), .en(en),
    .s_i({c_sxy_r, 16'b0}),
    .root_o(rho)
  );

  c2p_sqrt #(.N(c2p_pkg::RAD_N)) u_rad_sqrt (
    .clk(clk), .en(en), .s_i(c_srad_r), .root_o(rad_early)
  );

  c2p_delay #(.W(c2p_pkg::RAD_N), .DEPTH(9 + CORDIC_STEPS)) u_rad_dly (
    .clk(clk), .en(en), .d_i(rad_early), .q_o(rad_final)
  );

  // azimuth CORDIC, then align with the polar-angle path
  logic signed [CW-1:0] az_acc, az_acc_al;

  c2p_cordic #(.STEPS(CORDIC_STEPS)) u_az_cordic (
    .clk(clk), .en(en), .vx_i(b_ax_r), .vy_i(b_ay_r), .acc_i('0), .acc_o(az_acc)
  );

  c2p_delay #(.W(CW), .DEPTH(27)) u_az_dly (
    .clk(clk), .en(en), .d_i(az_acc), .q_o(az_acc_al)
  );

  // side data up to the polar-angle start stage
  logic [SW-1:0]        side_mid;
  c2p_pkg::side_t       side_m, d_side_r, side_end;
  logic [SW-1:0]        side_end_bits;

  c2p_delay #(.W(SW), .DEPTH(26)) u_side_dly0 (
    .clk(clk), .en(en), .d_i(b_side_r), .q_o(side_mid)
  );
  assign side_m = c2p_pkg::side_t'(side_mid);

  // stage d: polar-angle CORDIC start vector
  logic signed [CW-1:0] zs, rho_e;
  logic signed [CW-1:0] d_vx_r, d_vy_r, d_acc_r;

  assign zs    = CW'($signed(side_m.z)) <<< c2p_pkg::FRAC_SHIFT;
  assign rho_e = CW'(rho);

  always_ff @(posedge clk) begin
    if (en) begin
      d_side_r <= side_m;
      if (zs[CW-1]) begin
        // rotate by pi/2 to keep the vector in the right half-plane
        d_vx_r  <= rho_e;
        d_vy_r  <= -zs;
        d_acc_r <= c2p_pkg::HALF_PI_24;
      end else begin
        d_vx_r  <= zs;
        d_vy_r  <= rho_e;
        d_acc_r <= '0;
      end
    end
  end

  logic signed [CW-1:0] phi_acc;

  c2p_cordic #(.STEPS(CORDIC_STEPS)) u_phi_cordic (
    .clk(clk), .en(en), .vx_i(d_vx_r), .vy_i(d_vy_r), .acc_i(d_acc_r), .acc_o(phi_acc)
  );

  c2p_delay #(.W(SW), .DEPTH(CORDIC_STEPS)) u_side_dly1 (
    .clk(clk), .en(en), .d_i(d_side_r), .q_o(side_end_bits)
  );
  assign side_end = c2p_pkg::side_t'(side_end_bits);

  // final stage: Q2.13 rounding, clamps and special cases
  logic signed [CW-1:0] az_q, phi_q, az_c, phi_c;
  logic                 inv;
  logic [DW-1:0]        out_rad_r;
  logic signed [14:0]   out_az_r;
  logic signed [DW-1:0] out_third_r;
  logic                 out_inv_r;

  always_comb begin
    az_q  = (az_acc_al + c2p_pkg::ROUND_Q13) >>> 11;
    phi_q = (phi_acc + c2p_pkg::ROUND_Q13) >>> 11;
    az_c  = az_q;
    if (az_q < -c2p_pkg::HALF_PI_Q13) az_c = -c2p_pkg::HALF_PI_Q13;
    if (az_q > c2p_pkg::HALF_PI_Q13)  az_c = c2p_pkg::HALF_PI_Q13;
    phi_c = phi_q;
    if (phi_q < 0)               phi_c = '0;
    if (phi_q > c2p_pkg::PI_Q13) phi_c = c2p_pkg::PI_Q13;
    inv = side_end.xzero & side_end.yzero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad_r <= DW'(rad_final);
      out_inv_r <= inv;
      if (inv) begin
        out_az_r <= '0;
      end else if (side_end.xzero) begin
        out_az_r <= side_end.yneg ? 15'(-c2p_pkg::HALF_PI_Q13) : 15'(c2p_pkg::HALF_PI_Q13);
      end else begin
        out_az_r <= 15'(az_c);
      end
      if (!side_end.mode) begin
        out_third_r <= side_end.z;
      end else if (inv) begin
        out_third_r <= '0;
      end else begin
        out_third_r <= DW'(phi_c);
      end
    end
  end

  assign out_ch.radius      = out_rad_r;
  assign out_ch.azimuth     = out_az_r;
  assign out_ch.third_coord = out_third_r;
  assign out_ch.invalid     = out_inv_r;
endmodule

@@ rtl/c2p_checker.sv @@
// c2p_checker: port-level checks of the converter, bound to the top level.
// Depends on c2p_pkg for widths.
`timescale 1ns / 1ps
module c2p_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic        [c2p_pkg::DATA_WIDTH-1:0] radius,
  input logic signed [14:0]                    azimuth,
  input logic signed [c2p_pkg::DATA_WIDTH-1:0] third_coord,
  input logic                                  invalid
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(radius) && $stable(azimuth)
      && $stable(third_coord) && $stable(invalid))
    else $error("result changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_inv_az: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && invalid |-> azimuth == 15'sd0)
    else $error("azimuth nonzero on invalid point");

  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> azimuth >= -15'sd12868 && azimuth <= 15'sd12868)
    else $error("azimuth out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind cartesian_to_polar_coords c2p_checker u_c2p_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .radius(out_ch.radius), .azimuth(out_ch.azimuth),
  .third_coord(out_ch.third_coord), .invalid(out_ch.invalid)
);
